FILE: hdl/epc_pkg.sv
// ---------------------------------------------------------------------------
// epc_pkg
// Shared constants and the month start table for the epoch seconds to
// calendar converter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package epc_pkg;

  // seconds from 1970-01-01 to 2000-01-01
  localparam logic [31:0] EPOCH_2000_OFFSET = 32'd946684800;

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
  localparam logic [10:0] DAYS_PER_QUAD = 11'd1461;
  localparam logic [8:0]  DAYS_LEAP     = 9'd366;
  localparam logic [8:0]  DAYS_COMMON   = 9'd365;

  // floor reciprocals; quotient is low by at most one, fixed by one compare
  localparam logic [31:0] RECIP_DAY  = 32'd3257812230;  // 2^48 / 86400
  localparam logic [20:0] RECIP_HOUR = 21'd1193046;     // 2^32 / 3600
  localparam logic [21:0] RECIP_QUAD = 22'd2939744;     // 2^32 / 1461
  localparam logic [18:0] RECIP_MIN  = 19'd279620;      // 2^24 / 60

  localparam int unsigned MONTHS = 12;

  // day of year at which month idx (0 = January) starts
  function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
    logic [8:0] base;
    case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    // february 29 shifts every later month by one day
    if (leap && idx >= 4'd2) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

FILE: hdl/epc_month_decode.sv
// ---------------------------------------------------------------------------
// epc_month_decode
// Splits a zero-based day of year into month and day of month, using
// parallel compares against the month start table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module epc_month_decode (
  input  logic [8:0] day_of_year,
  input  logic       leap,
  output logic [3:0] month,
  output logic [4:0] day_of_month
);

  logic [3:0] month_idx;
  logic [8:0] day_offset;

  // last month whose start is not past the day of year
  always_comb begin
    month_idx = 4'd0;
    for (int k = 1; k < epc_pkg::MONTHS; k++) begin
      if (day_of_year >= epc_pkg::month_start(4'(k), leap)) begin
        month_idx = 4'(k);
      end
    end
  end

  // one-based month and day
  assign day_offset   = day_of_year - epc_pkg::month_start(month_idx, leap) + 9'd1;
  assign day_of_month = day_offset[4:0];
  assign month        = month_idx + 4'd1;

endmodule

FILE: hdl/epoch_seconds_to_calendar.sv
// ---------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Converts seconds since 1970 into UTC time and date counted from 2000,
// with every fourth year leap (2100 included).
//
//   channel   handshake                  payload
//   input     item_valid / item_stall    unix_seconds
//   output    result_valid / result_stall second, minute, hour, day_of_month,
//                                         month, year_since_2000, out_of_range
//
// One timestamp is taken every cycle while item_stall is low; each result passes through stage registers s1 to s7.
// The cycle time is set by the 32 x 32 reciprocal multiply for the day split.
// rst (synchronous) clears only the stage valid bits.
// A stalled output holds its beat; stages behind it keep filling empty slots
// and stall only once every stage ahead of them is occupied.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module epoch_seconds_to_calendar (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [31:0] unix_seconds,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [5:0]  second,
  output logic [5:0]  minute,
  output logic [4:0]  hour,
  output logic [4:0]  day_of_month,
  output logic [3:0]  month,
  output logic [6:0]  year_since_2000,
  output logic        out_of_range
);

  localparam int unsigned STAGES = 7;

  typedef struct packed {
    logic        oor;
    logic [31:0] secs;
  } s1_t;

  typedef struct packed {
    logic        oor;
    logic [31:0] secs;
    logic [15:0] day_q;
  } s2_t;

  typedef struct packed {
    logic        oor;
    logic [15:0] days;
    logic [16:0] sod;
  } s3_t;

  typedef struct packed {
    logic        oor;
    logic [15:0] days;
    logic [16:0] sod;
    logic [5:0]  hour_q;
    logic [5:0]  quad_q;
  } s4_t;

  typedef struct packed {
    logic        oor;
    logic [4:0]  hour;
    logic [11:0] soh;
    logic [4:0]  quads;
    logic [11:0] doq;
  } s5_t;

  typedef struct packed {
    logic        oor;
    logic [4:0]  hour;
    logic [11:0] soh;
    logic [5:0]  min_q;
    logic [6:0]  year;
    logic [8:0]  doy;
    logic        leap;
  } s6_t;

  typedef struct packed {
    logic        oor;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day_of_month;
    logic [3:0]  month;
    logic [6:0]  year;
  } s7_t;

  logic [STAGES:1]   vld;
  logic [STAGES+1:1] rdy;

  s1_t s1, s1_next;
  s2_t s2, s2_next;
  s3_t s3, s3_next;
  s4_t s4, s4_next;
  s5_t s5, s5_next;
  s6_t s6, s6_next;
  s7_t s7, s7_next;

  // a stage takes a beat when empty or when the one ahead moves
  always_comb begin
    rdy[STAGES+1] = !result_stall;
    for (int k = STAGES; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign item_stall   = !rdy[1];
  assign result_valid = vld[STAGES];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) vld[1] <= item_valid;
      for (int k = 2; k <= STAGES; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // stage 1: range check and rebase to 2000
  always_comb begin
    s1_next.oor  = unix_seconds < epc_pkg::EPOCH_2000_OFFSET;
    s1_next.secs = unix_seconds - epc_pkg::EPOCH_2000_OFFSET;
  end

  // stage 2: reciprocal estimate of the day count
  logic [63:0] day_prod;
  always_comb begin
    day_prod      = 64'(s1.secs) * 64'(epc_pkg::RECIP_DAY);
    s2_next.oor   = s1.oor;
    s2_next.secs  = s1.secs;
    s2_next.day_q = day_prod[63:48];
  end

  // stage 3: day remainder and quotient fix
  logic [32:0] day_rem;
  always_comb begin
    day_rem     = {1'b0, s2.secs} - 33'(s2.day_q) * 33'(epc_pkg::SECS_PER_DAY);
    s3_next.oor = s2.oor;
    if (day_rem[17:0] >= 18'(epc_pkg::SECS_PER_DAY)) begin
      s3_next.days = s2.day_q + 16'd1;
      s3_next.sod  = 17'(day_rem[17:0] - 18'(epc_pkg::SECS_PER_DAY));
    end else begin
      s3_next.days = s2.day_q;
      s3_next.sod  = day_rem[16:0];
    end
  end

  // stage 4: reciprocal estimates of hour and four-year group
  logic [37:0] hour_prod;
  logic [37:0] quad_prod;
  always_comb begin
    hour_prod      = 38'(s3.sod) * 38'(epc_pkg::RECIP_HOUR);
    quad_prod      = 38'(s3.days) * 38'(epc_pkg::RECIP_QUAD);
    s4_next.oor    = s3.oor;
    s4_next.days   = s3.days;
    s4_next.sod    = s3.sod;
    s4_next.hour_q = hour_prod[37:32];
    s4_next.quad_q = quad_prod[37:32];
  end

  // stage 5: hour and group remainders with quotient fix
  logic [17:0] hour_rem;
  logic [16:0] quad_rem;
  logic [5:0]  hour_fix;
  logic [5:0]  quad_fix;
  always_comb begin
    hour_rem    = {1'b0, s4.sod} - 18'(s4.hour_q) * 18'(epc_pkg::SECS_PER_HOUR);
    quad_rem    = {1'b0, s4.days} - 17'(s4.quad_q) * 17'(epc_pkg::DAYS_PER_QUAD);
    s5_next.oor = s4.oor;
    if (hour_rem[12:0] >= 13'(epc_pkg::SECS_PER_HOUR)) begin
      hour_fix    = s4.hour_q + 6'd1;
      s5_next.soh = 12'(hour_rem[12:0] - 13'(epc_pkg::SECS_PER_HOUR));
    end else begin
      hour_fix    = s4.hour_q;
      s5_next.soh = hour_rem[11:0];
    end
    if (quad_rem[11:0] >= 12'(epc_pkg::DAYS_PER_QUAD)) begin
      quad_fix    = s4.quad_q + 6'd1;
      s5_next.doq = quad_rem[11:0] - 12'(epc_pkg::DAYS_PER_QUAD);
    end else begin
      quad_fix    = s4.quad_q;
      s5_next.doq = quad_rem[11:0];
    end
    s5_next.hour  = hour_fix[4:0];
    s5_next.quads = quad_fix[4:0];
  end

  // stage 6: minute estimate and year within the four-year group
  logic [30:0] min_prod;
  logic [11:0] after_leap;
  logic [1:0]  year_off;
  always_comb begin
    min_prod      = 31'(s5.soh) * 31'(epc_pkg::RECIP_MIN);
    after_leap    = s5.doq - 12'(epc_pkg::DAYS_LEAP);
    s6_next.oor   = s5.oor;
    s6_next.hour  = s5.hour;
    s6_next.soh   = s5.soh;
    s6_next.min_q = min_prod[29:24];
    if (s5.doq < 12'(epc_pkg::DAYS_LEAP)) begin
      year_off     = 2'd0;
      s6_next.doy  = s5.doq[8:0];
      s6_next.leap = 1'b1;
    end else if (after_leap >= 12'(2 * epc_pkg::DAYS_COMMON)) begin
      year_off     = 2'd3;
      s6_next.doy  = 9'(after_leap - 12'(2 * epc_pkg::DAYS_COMMON));
      s6_next.leap = 1'b0;
    end else if (after_leap >= 12'(epc_pkg::DAYS_COMMON)) begin
      year_off     = 2'd2;
      s6_next.doy  = 9'(after_leap - 12'(epc_pkg::DAYS_COMMON));
      s6_next.leap = 1'b0;
    end else begin
      year_off     = 2'd1;
      s6_next.doy  = after_leap[8:0];
      s6_next.leap = 1'b0;
    end
    s6_next.year = {s5.quads, year_off};
  end

  // stage 7: minute fix, month split and range mask
  logic [11:0] min_rem;
  logic [5:0]  min_val;
  logic [5:0]  sec_val;
  logic [3:0]  month_val;
  logic [4:0]  dom_val;

  epc_month_decode u_month (
    .day_of_year  (s6.doy),
    .leap         (s6.leap),
    .month        (month_val),
    .day_of_month (dom_val)
  );

  always_comb begin
    min_rem = s6.soh - 12'(s6.min_q) * 12'(epc_pkg::SECS_PER_MIN);
    if (min_rem >= 12'(epc_pkg::SECS_PER_MIN)) begin
      min_val = s6.min_q + 6'd1;
      sec_val = 6'(min_rem - 12'(epc_pkg::SECS_PER_MIN));
    end else begin
      min_val = s6.min_q;
      sec_val = min_rem[5:0];
    end
    s7_next.oor = s6.oor;
    if (s6.oor) begin
      s7_next.second       = '0;
      s7_next.minute       = '0;
      s7_next.hour         = '0;
      s7_next.day_of_month = '0;
      s7_next.month        = '0;
      s7_next.year         = '0;
    end else begin
      s7_next.second       = sec_val;
      s7_next.minute       = min_val;
      s7_next.hour         = s6.hour;
      s7_next.day_of_month = dom_val;
      s7_next.month        = month_val;
      s7_next.year         = s6.year;
    end
  end

  // payload registers load with their stage
  always_ff @(posedge clk) begin
    if (rdy[1]) s1 <= s1_next;
    if (rdy[2]) s2 <= s2_next;
    if (rdy[3]) s3 <= s3_next;
    if (rdy[4]) s4 <= s4_next;
    if (rdy[5]) s5 <= s5_next;
    if (rdy[6]) s6 <= s6_next;
    if (rdy[7]) s7 <= s7_next;
  end

  // result beat
  assign second          = s7.second;
  assign minute          = s7.minute;
  assign hour            = s7.hour;
  assign day_of_month    = s7.day_of_month;
  assign month           = s7.month;
  assign year_since_2000 = s7.year;
  assign out_of_range    = s7.oor;

endmodule
